@@ rtl/scc_pkg.sv @@
// ---------------------------------------------------------------------------
// scc_pkg
// Shared constants, codes and beat types of the strongly connected
// components block.
// ---------------------------------------------------------------------------
package scc_pkg;

   // graph capacity
   localparam int MAX_NODES = 1024;
   localparam int MAX_EDGES = 4096;

   // field and storage widths
   localparam int KIND_W  = 3;
   localparam int STAT_W  = 2;
   localparam int NODE_W  = $clog2(MAX_NODES);
   localparam int NCNT_W  = $clog2(MAX_NODES + 1);
   localparam int EADDR_W = $clog2(MAX_EDGES);
   localparam int ECNT_W  = $clog2(MAX_EDGES + 1);
   localparam int DEG_W   = 13;

   // request kinds
   localparam logic [KIND_W-1:0] KIND_ADD   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_RUN   = 3'd1;
   localparam logic [KIND_W-1:0] KIND_QNODE = 3'd2;
   localparam logic [KIND_W-1:0] KIND_QCOMP = 3'd3;
   localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd4;

   // response status codes
   localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
   localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
   localparam logic [STAT_W-1:0] ST_PHASE = 2'd3;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [NODE_W-1:0] first_index;
      logic [NODE_W-1:0] second_index;
   } scc_req_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [NODE_W-1:0] component_id;
      logic [NCNT_W-1:0] component_total;
      logic [DEG_W-1:0]  in_degree;
      logic [DEG_W-1:0]  out_degree;
   } scc_rsp_type;

endpackage

@@ rtl/scc_if.sv @@
// ---------------------------------------------------------------------------
// scc channel interfaces
// Valid/ready channels for request beats, response beats and the
// node count register write.
// ---------------------------------------------------------------------------
interface scc_req_if;
   logic                        valid;
   logic                        ready;
   logic [scc_pkg::KIND_W-1:0]  kind;
   logic [scc_pkg::NODE_W-1:0]  first_index;
   logic [scc_pkg::NODE_W-1:0]  second_index;
   modport source (output valid, kind, first_index, second_index, input ready);
   modport sink (input valid, kind, first_index, second_index, output ready);
endinterface

interface scc_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [scc_pkg::STAT_W-1:0]  status;
   logic [scc_pkg::NODE_W-1:0]  component_id;
   logic [scc_pkg::NCNT_W-1:0]  component_total;
   logic [scc_pkg::DEG_W-1:0]   in_degree;
   logic [scc_pkg::DEG_W-1:0]   out_degree;
   modport source (output valid, status, component_id, component_total, in_degree,
                   out_degree, input ready);
   modport sink (input valid, status, component_id, component_total, in_degree,
                 out_degree, output ready);
endinterface

interface scc_csr_if;
   logic                        valid;
   logic                        ready;
   logic [scc_pkg::NCNT_W-1:0]  data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

@@ rtl/strongly_connected_components.sv @@
// ---------------------------------------------------------------------------
// strongly_connected_components
// Kosaraju component search over a loaded directed graph, with node count
// register, request/response channels and a registered response beat.
// ---------------------------------------------------------------------------
// Edge beats are stored in arrival order (up to 4096), a run beat finds the
// strongly connected components of nodes 0..node_count-1, and query beats
// read a node's component or a component's condensed degrees. Every request
// beat gives exactly one response beat. An edge add, clear or unknown kind
// answers straight from the idle state, a component query after a degree
// read and a node query after a component read and a degree read, set by
// the sequential memory reads of the sequencer. A run does two adjacency
// builds and two depth-first walks with an explicit stack, each edge and
// node costing dependent memory round trips. The response register lets
// the next request beat be taken while a response waits. The node count
// register accepts a write every cycle and is to be written only while the
// block is idle.
module strongly_connected_components (
   input logic      clock,
   input logic      reset,
   scc_req_if.sink  req_chan,
   scc_rsp_if.source rsp_chan,
   scc_csr_if.sink  csr_chan
);
   import scc_pkg::*;

   logic [NCNT_W-1:0] node_count_ff, node_count_in;
   logic              cfg_drop;
   scc_req_type       cmd;
   logic              cmd_ready;
   logic              res_valid, res_ready;
   scc_rsp_type       res;
   logic              rsp_valid_ff, rsp_valid_in;
   scc_rsp_type       rsp_ff, rsp_in;

   // node count register with clamping
   assign csr_chan.ready = 1'b1;
   assign cfg_drop       = csr_chan.valid;

   always_comb begin
      node_count_in = node_count_ff;
      if (csr_chan.valid) begin
         if (csr_chan.data == '0) begin
            node_count_in = NCNT_W'(1);
         end else if (csr_chan.data > NCNT_W'(MAX_NODES)) begin
            node_count_in = NCNT_W'(MAX_NODES);
         end else begin
            node_count_in = csr_chan.data;
         end
      end
   end

   // request beat into the sequencer
   assign cmd            = '{kind: req_chan.kind, first_index: req_chan.first_index,
                             second_index: req_chan.second_index};
   assign req_chan.ready = cmd_ready;

   scc_core u_core (
      .clock,
      .reset,
      .node_count (node_count_ff),
      .cfg_drop,
      .cmd_valid  (req_chan.valid),
      .cmd_ready,
      .cmd,
      .res_valid,
      .res_ready,
      .res
   );

   // response output register
   assign res_ready = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= NCNT_W'(MAX_NODES);
         rsp_valid_ff  <= 1'b0;
      end else begin
         node_count_ff <= node_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.status          = rsp_ff.status;
   assign rsp_chan.component_id    = rsp_ff.component_id;
   assign rsp_chan.component_total = rsp_ff.component_total;
   assign rsp_chan.in_degree       = rsp_ff.in_degree;
   assign rsp_chan.out_degree      = rsp_ff.out_degree;
endmodule

@@ rtl/scc_ram.sv @@
// ---------------------------------------------------------------------------
// scc_ram
// Simple dual port memory, one write and one read port, registered read.
// ---------------------------------------------------------------------------
module scc_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

@@ rtl/scc_core.sv @@
// ---------------------------------------------------------------------------
// scc_core
// Sequencer for edge loads, queries and the two-pass component search;
// all graph state lives in on-chip memories.
// ---------------------------------------------------------------------------
module scc_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [scc_pkg::NCNT_W-1:0] node_count,
   input  logic                       cfg_drop,
   input  logic                       cmd_valid,
   output logic                       cmd_ready,
   input  scc_pkg::scc_req_type       cmd,
   output logic                       res_valid,
   input  logic                       res_ready,
   output scc_pkg::scc_rsp_type       res
);
   import scc_pkg::*;

   localparam int SADDR_W = $clog2(MAX_NODES + 1);
   localparam int FRAME_W = NODE_W + 2 * ECNT_W;

   // sequencer states
   localparam logic [4:0] S_IDLE   = 5'd0;
   localparam logic [4:0] S_QN_C   = 5'd1;
   localparam logic [4:0] S_QN_D   = 5'd2;
   localparam logic [4:0] S_RESP   = 5'd3;
   localparam logic [4:0] S_SCLR   = 5'd4;
   localparam logic [4:0] S_CNT_RD = 5'd5;
   localparam logic [4:0] S_CNT_E  = 5'd6;
   localparam logic [4:0] S_CNT_W  = 5'd7;
   localparam logic [4:0] S_PRE_RD = 5'd8;
   localparam logic [4:0] S_PRE_W  = 5'd9;
   localparam logic [4:0] S_FIL_RD = 5'd10;
   localparam logic [4:0] S_FIL_E  = 5'd11;
   localparam logic [4:0] S_FIL_W  = 5'd12;
   localparam logic [4:0] S_VCLR   = 5'd13;
   localparam logic [4:0] S_O1     = 5'd14;
   localparam logic [4:0] S_O2     = 5'd15;
   localparam logic [4:0] S_OCHK   = 5'd16;
   localparam logic [4:0] S_ST0    = 5'd17;
   localparam logic [4:0] S_ST1    = 5'd18;
   localparam logic [4:0] S_STEP   = 5'd19;
   localparam logic [4:0] S_LST    = 5'd20;
   localparam logic [4:0] S_VIS    = 5'd21;
   localparam logic [4:0] S_POP    = 5'd22;
   localparam logic [4:0] S_DCLR   = 5'd23;
   localparam logic [4:0] S_DEG_RD = 5'd24;
   localparam logic [4:0] S_DEG_E  = 5'd25;
   localparam logic [4:0] S_DEG_S  = 5'd26;
   localparam logic [4:0] S_DEG_T  = 5'd27;
   localparam logic [4:0] S_DEG_W  = 5'd28;

   // control registers
   logic [4:0]        state_ff, state_in;
   logic              ready_ff, ready_in;
   logic [NCNT_W-1:0] ccount_ff, ccount_in;
   logic [ECNT_W-1:0] etotal_ff, etotal_in;
   // working registers
   logic              dir_ff, dir_in;
   logic [ECNT_W-1:0] idx_ff, idx_in;
   logic [ECNT_W-1:0] acc_ff, acc_in;
   logic [NODE_W-1:0] u_ff, u_in;
   logic [ECNT_W-1:0] p_ff, p_in;
   logic [ECNT_W-1:0] lim_ff, lim_in;
   logic [NCNT_W-1:0] depth_ff, depth_in;
   logic [NCNT_W-1:0] flen_ff, flen_in;
   logic [NODE_W-1:0] v_ff, v_in;
   logic [NODE_W-1:0] ea_ff, ea_in;
   logic [NODE_W-1:0] eb_ff, eb_in;
   logic [NODE_W-1:0] cs_ff, cs_in;
   scc_rsp_type       res_ff, res_in;

   // memory ports
   logic                  e_we;
   logic [EADDR_W-1:0]    e_wa, e_ra;
   logic [2*NODE_W-1:0]   e_wd, e_rd;
   logic                  st_we;
   logic [SADDR_W-1:0]    st_wa, st_ra;
   logic [ECNT_W-1:0]     st_wd, st_rd;
   logic                  cur_we;
   logic [NODE_W-1:0]     cur_wa, cur_ra;
   logic [ECNT_W-1:0]     cur_wd, cur_rd;
   logic                  lst_we;
   logic [EADDR_W-1:0]    lst_wa, lst_ra;
   logic [NODE_W-1:0]     lst_wd, lst_rd;
   logic                  vis_we;
   logic [NODE_W-1:0]     vis_wa, vis_ra;
   logic                  vis_wd, vis_rd;
   logic                  fin_we;
   logic [NODE_W-1:0]     fin_wa, fin_ra;
   logic [NODE_W-1:0]     fin_wd, fin_rd;
   logic                  stk_we;
   logic [NODE_W-1:0]     stk_wa, stk_ra;
   logic [FRAME_W-1:0]    stk_wd, stk_rd;
   logic                  comp_we;
   logic [NODE_W-1:0]     comp_wa, comp_ra;
   logic [NODE_W-1:0]     comp_wd, comp_rd;
   logic                  inc_we;
   logic [NODE_W-1:0]     inc_wa, inc_ra;
   logic [DEG_W-1:0]      inc_wd, inc_rd;
   logic                  outc_we;
   logic [NODE_W-1:0]     outc_wa, outc_ra;
   logic [DEG_W-1:0]      outc_wd, outc_rd;

   // helper values
   logic [ECNT_W-1:0] nc_ext, idx_dec, idx_inc, pre_sum;
   logic [NCNT_W-1:0] depth_m1, depth_m2;
   logic [NODE_W-1:0] e_src, e_dst, e_from, e_to;
   logic              e_usable;

   assign nc_ext   = ECNT_W'(node_count);
   assign idx_dec  = idx_ff - ECNT_W'(1);
   assign idx_inc  = idx_ff + ECNT_W'(1);
   assign pre_sum  = acc_ff + st_rd;
   assign depth_m1 = depth_ff - NCNT_W'(1);
   assign depth_m2 = depth_ff - NCNT_W'(2);
   assign e_src    = e_rd[2*NODE_W-1:NODE_W];
   assign e_dst    = e_rd[NODE_W-1:0];
   assign e_from   = dir_ff ? e_dst : e_src;
   assign e_to     = dir_ff ? e_src : e_dst;
   assign e_usable = (NCNT_W'(e_src) < node_count) && (NCNT_W'(e_dst) < node_count);

   // memories
   scc_ram #(.DEPTH(MAX_EDGES), .WIDTH(2*NODE_W)) u_edge_ram (
      .clock, .wr_en(e_we), .wr_addr(e_wa), .wr_data(e_wd), .rd_addr(e_ra), .rd_data(e_rd));
   scc_ram #(.DEPTH(MAX_NODES+1), .WIDTH(ECNT_W)) u_start_ram (
      .clock, .wr_en(st_we), .wr_addr(st_wa), .wr_data(st_wd), .rd_addr(st_ra),
      .rd_data(st_rd));
   scc_ram #(.DEPTH(MAX_NODES), .WIDTH(ECNT_W)) u_cursor_ram (
      .clock, .wr_en(cur_we), .wr_addr(cur_wa), .wr_data(cur_wd), .rd_addr(cur_ra),
      .rd_data(cur_rd));
   scc_ram #(.DEPTH(MAX_EDGES), .WIDTH(NODE_W)) u_list_ram (
      .clock, .wr_en(lst_we), .wr_addr(lst_wa), .wr_data(lst_wd), .rd_addr(lst_ra),
      .rd_data(lst_rd));
   scc_ram #(.DEPTH(MAX_NODES), .WIDTH(1)) u_visit_ram (
      .clock, .wr_en(vis_we), .wr_addr(vis_wa), .wr_data(vis_wd), .rd_addr(vis_ra),
      .rd_data(vis_rd));
   scc_ram #(.DEPTH(MAX_NODES), .WIDTH(NODE_W)) u_finish_ram (
      .clock, .wr_en(fin_we), .wr_addr(fin_wa), .wr_data(fin_wd), .rd_addr(fin_ra),
      .rd_data(fin_rd));
   scc_ram #(.DEPTH(MAX_NODES), .WIDTH(FRAME_W)) u_stack_ram (
      .clock, .wr_en(stk_we), .wr_addr(stk_wa), .wr_data(stk_wd), .rd_addr(stk_ra),
      .rd_data(stk_rd));
   scc_ram #(.DEPTH(MAX_NODES), .WIDTH(NODE_W)) u_comp_ram (
      .clock, .wr_en(comp_we), .wr_addr(comp_wa), .wr_data(comp_wd), .rd_addr(comp_ra),
      .rd_data(comp_rd));
   scc_ram #(.DEPTH(MAX_NODES), .WIDTH(DEG_W)) u_indeg_ram (
      .clock, .wr_en(inc_we), .wr_addr(inc_wa), .wr_data(inc_wd), .rd_addr(inc_ra),
      .rd_data(inc_rd));
   scc_ram #(.DEPTH(MAX_NODES), .WIDTH(DEG_W)) u_outdeg_ram (
      .clock, .wr_en(outc_we), .wr_addr(outc_wa), .wr_data(outc_wd), .rd_addr(outc_ra),
      .rd_data(outc_rd));

   // sequencer
   always_comb begin
      state_in  = state_ff;
      ready_in  = ready_ff;
      ccount_in = ccount_ff;
      etotal_in = etotal_ff;
      dir_in    = dir_ff;
      idx_in    = idx_ff;
      acc_in    = acc_ff;
      u_in      = u_ff;
      p_in      = p_ff;
      lim_in    = lim_ff;
      depth_in  = depth_ff;
      flen_in   = flen_ff;
      v_in      = v_ff;
      ea_in     = ea_ff;
      eb_in     = eb_ff;
      cs_in     = cs_ff;
      res_in    = res_ff;
      cmd_ready = 1'b0;
      res_valid = 1'b0;
      e_we = 1'b0;    e_wa = '0;    e_wd = '0;    e_ra = idx_ff[EADDR_W-1:0];
      st_we = 1'b0;   st_wa = '0;   st_wd = '0;   st_ra = '0;
      cur_we = 1'b0;  cur_wa = '0;  cur_wd = '0;  cur_ra = '0;
      lst_we = 1'b0;  lst_wa = '0;  lst_wd = '0;  lst_ra = '0;
      vis_we = 1'b0;  vis_wa = '0;  vis_wd = 1'b0; vis_ra = '0;
      fin_we = 1'b0;  fin_wa = '0;  fin_wd = '0;  fin_ra = '0;
      stk_we = 1'b0;  stk_wa = '0;  stk_wd = '0;  stk_ra = '0;
      comp_we = 1'b0; comp_wa = '0; comp_wd = '0; comp_ra = '0;
      inc_we = 1'b0;  inc_wa = '0;  inc_wd = '0;  inc_ra = '0;
      outc_we = 1'b0; outc_wa = '0; outc_wd = '0; outc_ra = '0;

      unique case (state_ff)
         // take a request beat
         S_IDLE: begin
            cmd_ready = 1'b1;
            if (cmd_valid) begin
               res_in   = '0;
               state_in = S_RESP;
               unique case (cmd.kind)
                  KIND_ADD: begin
                     if ((NCNT_W'(cmd.first_index) >= node_count) ||
                         (NCNT_W'(cmd.second_index) >= node_count)) begin
                        res_in.status = ST_RANGE;
                     end else if (etotal_ff >= ECNT_W'(MAX_EDGES)) begin
                        res_in.status = ST_FULL;
                     end else begin
                        e_we      = 1'b1;
                        e_wa      = etotal_ff[EADDR_W-1:0];
                        e_wd      = {cmd.first_index, cmd.second_index};
                        etotal_in = etotal_ff + ECNT_W'(1);
                        ready_in  = 1'b0;
                     end
                  end
                  KIND_RUN: begin
                     dir_in   = 1'b0;
                     idx_in   = '0;
                     state_in = S_SCLR;
                  end
                  KIND_QNODE: begin
                     if (!ready_ff) begin
                        res_in.status = ST_PHASE;
                     end else if (NCNT_W'(cmd.first_index) >= node_count) begin
                        res_in.status = ST_RANGE;
                     end else begin
                        comp_ra  = cmd.first_index;
                        state_in = S_QN_C;
                     end
                  end
                  KIND_QCOMP: begin
                     if (!ready_ff) begin
                        res_in.status = ST_PHASE;
                     end else if (NCNT_W'(cmd.first_index) >= ccount_ff) begin
                        res_in.status = ST_RANGE;
                     end else begin
                        inc_ra              = cmd.first_index;
                        outc_ra             = cmd.first_index;
                        res_in.component_id = cmd.first_index;
                        state_in            = S_QN_D;
                     end
                  end
                  KIND_CLEAR: begin
                     etotal_in = '0;
                     ready_in  = 1'b0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         // node query: component known, fetch its degrees
         S_QN_C: begin
            res_in.component_id = comp_rd;
            inc_ra              = comp_rd;
            outc_ra             = comp_rd;
            state_in            = S_QN_D;
         end
         S_QN_D: begin
            res_in.in_degree  = inc_rd;
            res_in.out_degree = outc_rd;
            state_in          = S_RESP;
         end
         // hand the result to the output register
         S_RESP: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         // adjacency build: clear bucket counts
         S_SCLR: begin
            st_we = 1'b1;
            st_wa = idx_ff[SADDR_W-1:0];
            if (idx_ff == nc_ext) begin
               idx_in   = '0;
               state_in = S_CNT_RD;
            end else begin
               idx_in = idx_inc;
            end
         end
         // adjacency build: count edges per node
         S_CNT_RD: begin
            if (idx_ff == etotal_ff) begin
               idx_in   = '0;
               acc_in   = '0;
               state_in = S_PRE_RD;
            end else begin
               state_in = S_CNT_E;
            end
         end
         S_CNT_E: begin
            ea_in = e_from;
            eb_in = e_to;
            if (e_usable) begin
               st_ra    = SADDR_W'(e_from) + SADDR_W'(1);
               state_in = S_CNT_W;
            end else begin
               idx_in   = idx_inc;
               state_in = S_CNT_RD;
            end
         end
         S_CNT_W: begin
            st_we    = 1'b1;
            st_wa    = SADDR_W'(ea_ff) + SADDR_W'(1);
            st_wd    = st_rd + ECNT_W'(1);
            idx_in   = idx_inc;
            state_in = S_CNT_RD;
         end
         // adjacency build: running sum into bucket starts and cursors
         S_PRE_RD: begin
            st_ra    = idx_ff[SADDR_W-1:0];
            state_in = S_PRE_W;
         end
         S_PRE_W: begin
            st_we  = 1'b1;
            st_wa  = idx_ff[SADDR_W-1:0];
            st_wd  = pre_sum;
            acc_in = pre_sum;
            if (idx_ff < nc_ext) begin
               cur_we = 1'b1;
               cur_wa = idx_ff[NODE_W-1:0];
               cur_wd = pre_sum;
            end
            if (idx_ff == nc_ext) begin
               idx_in   = '0;
               state_in = S_FIL_RD;
            end else begin
               idx_in   = idx_inc;
               state_in = S_PRE_RD;
            end
         end
         // adjacency build: scatter neighbors in insertion order
         S_FIL_RD: begin
            if (idx_ff == etotal_ff) begin
               idx_in   = '0;
               state_in = S_VCLR;
            end else begin
               state_in = S_FIL_E;
            end
         end
         S_FIL_E: begin
            ea_in = e_from;
            eb_in = e_to;
            if (e_usable) begin
               cur_ra   = e_from;
               state_in = S_FIL_W;
            end else begin
               idx_in   = idx_inc;
               state_in = S_FIL_RD;
            end
         end
         S_FIL_W: begin
            lst_we   = 1'b1;
            lst_wa   = cur_rd[EADDR_W-1:0];
            lst_wd   = eb_ff;
            cur_we   = 1'b1;
            cur_wa   = ea_ff;
            cur_wd   = cur_rd + ECNT_W'(1);
            idx_in   = idx_inc;
            state_in = S_FIL_RD;
         end
         // clear visited marks, then set up the root scan
         S_VCLR: begin
            vis_we = 1'b1;
            vis_wa = idx_ff[NODE_W-1:0];
            if (idx_inc == nc_ext) begin
               state_in = S_O1;
               if (!dir_ff) begin
                  idx_in  = '0;
                  flen_in = '0;
               end else begin
                  idx_in    = ECNT_W'(flen_ff);
                  ccount_in = '0;
               end
            end else begin
               idx_in = idx_inc;
            end
         end
         // root scan: index order forward, reverse finish order backward
         S_O1: begin
            if (!dir_ff) begin
               if (idx_ff == nc_ext) begin
                  dir_in   = 1'b1;
                  idx_in   = '0;
                  state_in = S_SCLR;
               end else begin
                  vis_ra   = idx_ff[NODE_W-1:0];
                  v_in     = idx_ff[NODE_W-1:0];
                  state_in = S_OCHK;
               end
            end else begin
               if (idx_ff == '0) begin
                  state_in = S_DCLR;
               end else begin
                  fin_ra   = idx_dec[NODE_W-1:0];
                  state_in = S_O2;
               end
            end
         end
         S_O2: begin
            v_in     = fin_rd;
            vis_ra   = fin_rd;
            state_in = S_OCHK;
         end
         S_OCHK: begin
            if (vis_rd) begin
               idx_in   = dir_ff ? idx_dec : idx_inc;
               state_in = S_O1;
            end else begin
               vis_we   = 1'b1;
               vis_wa   = v_ff;
               vis_wd   = 1'b1;
               u_in     = v_ff;
               depth_in = NCNT_W'(1);
               st_ra    = SADDR_W'(v_ff);
               state_in = S_ST0;
            end
         end
         // load the new top frame's edge range
         S_ST0: begin
            p_in     = st_rd;
            st_ra    = SADDR_W'(u_ff) + SADDR_W'(1);
            state_in = S_ST1;
         end
         S_ST1: begin
            lim_in   = st_rd;
            state_in = S_STEP;
         end
         // walk step: next neighbor or finish the top node
         S_STEP: begin
            if (p_ff < lim_ff) begin
               lst_ra   = p_ff[EADDR_W-1:0];
               p_in     = p_ff + ECNT_W'(1);
               state_in = S_LST;
            end else begin
               if (!dir_ff) begin
                  fin_we  = 1'b1;
                  fin_wa  = flen_ff[NODE_W-1:0];
                  fin_wd  = u_ff;
                  flen_in = flen_ff + NCNT_W'(1);
               end else begin
                  comp_we = 1'b1;
                  comp_wa = u_ff;
                  comp_wd = ccount_ff[NODE_W-1:0];
               end
               depth_in = depth_m1;
               if (depth_ff == NCNT_W'(1)) begin
                  state_in = S_O1;
                  if (dir_ff) begin
                     ccount_in = ccount_ff + NCNT_W'(1);
                     idx_in    = idx_dec;
                  end else begin
                     idx_in = idx_inc;
                  end
               end else begin
                  stk_ra   = depth_m2[NODE_W-1:0];
                  state_in = S_POP;
               end
            end
         end
         S_LST: begin
            v_in     = lst_rd;
            vis_ra   = lst_rd;
            state_in = S_VIS;
         end
         // unvisited neighbor: push the current frame and descend
         S_VIS: begin
            if (vis_rd) begin
               state_in = S_STEP;
            end else begin
               vis_we   = 1'b1;
               vis_wa   = v_ff;
               vis_wd   = 1'b1;
               stk_we   = 1'b1;
               stk_wa   = depth_m1[NODE_W-1:0];
               stk_wd   = {u_ff, p_ff, lim_ff};
               depth_in = depth_ff + NCNT_W'(1);
               u_in     = v_ff;
               st_ra    = SADDR_W'(v_ff);
               state_in = S_ST0;
            end
         end
         S_POP: begin
            {u_in, p_in, lim_in} = stk_rd;
            state_in             = S_STEP;
         end
         // degree phase: clear counters
         S_DCLR: begin
            inc_we  = 1'b1;
            inc_wa  = idx_ff[NODE_W-1:0];
            outc_we = 1'b1;
            outc_wa = idx_ff[NODE_W-1:0];
            if (idx_inc == nc_ext) begin
               idx_in   = '0;
               state_in = S_DEG_RD;
            end else begin
               idx_in = idx_inc;
            end
         end
         // degree phase: one edge at a time
         S_DEG_RD: begin
            if (idx_ff == etotal_ff) begin
               ready_in = 1'b1;
               res_in   = '0;
               state_in = S_RESP;
            end else begin
               state_in = S_DEG_E;
            end
         end
         S_DEG_E: begin
            ea_in = e_src;
            eb_in = e_dst;
            if (e_usable) begin
               comp_ra  = e_src;
               state_in = S_DEG_S;
            end else begin
               idx_in   = idx_inc;
               state_in = S_DEG_RD;
            end
         end
         S_DEG_S: begin
            cs_in    = comp_rd;
            comp_ra  = eb_ff;
            state_in = S_DEG_T;
         end
         S_DEG_T: begin
            if (cs_ff != comp_rd) begin
               outc_ra  = cs_ff;
               inc_ra   = comp_rd;
               v_in     = comp_rd;
               state_in = S_DEG_W;
            end else begin
               idx_in   = idx_inc;
               state_in = S_DEG_RD;
            end
         end
         S_DEG_W: begin
            outc_we  = 1'b1;
            outc_wa  = cs_ff;
            outc_wd  = (&outc_rd) ? outc_rd : outc_rd + DEG_W'(1);
            inc_we   = 1'b1;
            inc_wa   = v_ff;
            inc_wd   = (&inc_rd) ? inc_rd : inc_rd + DEG_W'(1);
            idx_in   = idx_inc;
            state_in = S_DEG_RD;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // a node count write drops the last run result
      if (cfg_drop) begin
         ready_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         ready_ff  <= 1'b0;
         ccount_ff <= '0;
         etotal_ff <= '0;
      end else begin
         state_ff  <= state_in;
         ready_ff  <= ready_in;
         ccount_ff <= ccount_in;
         etotal_ff <= etotal_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      dir_ff   <= dir_in;
      idx_ff   <= idx_in;
      acc_ff   <= acc_in;
      u_ff     <= u_in;
      p_ff     <= p_in;
      lim_ff   <= lim_in;
      depth_ff <= depth_in;
      flen_ff  <= flen_in;
      v_ff     <= v_in;
      ea_ff    <= ea_in;
      eb_ff    <= eb_in;
      cs_ff    <= cs_in;
      res_ff   <= res_in;
   end

   // component total reflects the held run result
   always_comb begin
      res                 = res_ff;
      res.component_total = ready_ff ? ccount_ff : '0;
   end
endmodule

@@ verif/tb_scc_scoreboard.sv @@
// ---------------------------------------------------------------------------
// scc graph predictor and response checker
// Keeps a private copy of the edge store, node count and last run result,
// predicts each response beat and compares it with what the block returns.
// ---------------------------------------------------------------------------
class scc_graph_checker;

   // graph state mirrored from accepted beats
   int unsigned node_total;
   int unsigned edge_src[$];
   int unsigned edge_dst[$];
   bit          run_valid;
   int unsigned comp_of[scc_pkg::MAX_NODES];
   int unsigned comp_in[scc_pkg::MAX_NODES];
   int unsigned comp_out[scc_pkg::MAX_NODES];
   int unsigned comp_found;

   scc_pkg::scc_rsp_type pending_rsp[$];
   int unsigned mismatch_count;
   int unsigned rsp_checked;

   function new();
      node_total = scc_pkg::MAX_NODES;
      run_valid = 0;
      comp_found = 0;
      mismatch_count = 0;
      rsp_checked = 0;
   endfunction

   function void write_node_count(int unsigned value);
      value = value & 11'h7FF;
      if (value == 0) value = 1;
      if (value > scc_pkg::MAX_NODES) value = scc_pkg::MAX_NODES;
      node_total = value;
      run_valid = 0;
   endfunction

   // explicit-stack walk, forward or reverse adjacency
   function void walk_from(int unsigned root, ref int unsigned adj_start[],
                           ref int unsigned adj_list[], ref bit seen[],
                           input bit record_finish, input int unsigned color,
                           ref int unsigned finish_seq[$]);
      int unsigned stk_node[$];
      int unsigned stk_pos[$];
      int unsigned u;
      int unsigned p;
      int unsigned v;
      seen[root] = 1;
      stk_node = {stk_node, root};
      stk_pos = {stk_pos, adj_start[root]};
      while (stk_node.size() > 0) begin
         u = stk_node[$];
         p = stk_pos[$];
         if (p < adj_start[u+1]) begin
            v = adj_list[p];
            stk_pos[$] = p + 1;
            if (!seen[v] && stk_node.size() < scc_pkg::MAX_NODES) begin
               seen[v] = 1;
               stk_node = {stk_node, v};
               stk_pos = {stk_pos, adj_start[v]};
            end
         end else begin
            void'(stk_node.pop_back());
            void'(stk_pos.pop_back());
            if (record_finish) finish_seq = {finish_seq, u};
            else comp_of[u] = color;
         end
      end
   endfunction

   function void build_adjacency(bit reverse, ref int unsigned adj_start[],
                                 ref int unsigned adj_list[]);
      int unsigned cursor[];
      int unsigned a;
      int unsigned b;
      adj_start = new[scc_pkg::MAX_NODES + 1];
      adj_list = new[edge_src.size() + 1];
      cursor = new[scc_pkg::MAX_NODES];
      foreach (adj_start[i]) adj_start[i] = 0;
      foreach (edge_src[e]) begin
         a = reverse ? edge_dst[e] : edge_src[e];
         b = reverse ? edge_src[e] : edge_dst[e];
         if (a < node_total && b < node_total) adj_start[a+1]++;
      end
      for (int i = 0; i < node_total; i++) adj_start[i+1] += adj_start[i];
      for (int i = node_total; i < scc_pkg::MAX_NODES; i++) adj_start[i+1] = adj_start[i];
      for (int i = 0; i < scc_pkg::MAX_NODES; i++) cursor[i] = adj_start[i];
      foreach (edge_src[e]) begin
         a = reverse ? edge_dst[e] : edge_src[e];
         b = reverse ? edge_src[e] : edge_dst[e];
         if (a < node_total && b < node_total) adj_list[cursor[a]++] = b;
      end
   endfunction

   function void find_components();
      int unsigned fwd_start[];
      int unsigned fwd_list[];
      int unsigned rev_start[];
      int unsigned rev_list[];
      bit          seen[];
      int unsigned finish_seq[$];
      int unsigned dummy[$];
      int unsigned v;
      int unsigned cs;
      int unsigned ct;
      build_adjacency(0, fwd_start, fwd_list);
      build_adjacency(1, rev_start, rev_list);
      seen = new[scc_pkg::MAX_NODES];
      for (int i = 0; i < node_total; i++)
         if (!seen[i]) walk_from(i, fwd_start, fwd_list, seen, 1, 0, finish_seq);
      seen = new[scc_pkg::MAX_NODES];
      comp_found = 0;
      for (int k = finish_seq.size(); k > 0; k--) begin
         v = finish_seq[k-1];
         if (!seen[v]) begin
            walk_from(v, rev_start, rev_list, seen, 0, comp_found, dummy);
            comp_found++;
         end
      end
      foreach (comp_in[i]) begin
         comp_in[i] = 0;
         comp_out[i] = 0;
      end
      foreach (edge_src[e]) begin
         if (edge_src[e] < node_total && edge_dst[e] < node_total) begin
            cs = comp_of[edge_src[e]];
            ct = comp_of[edge_dst[e]];
            if (cs != ct) begin
               comp_out[cs]++;
               comp_in[ct]++;
            end
         end
      end
      run_valid = 1;
   endfunction

   function int unsigned cap_degree(int unsigned d);
      return (d > 8191) ? 8191 : d;
   endfunction

   // note one accepted request beat and queue its response
   function void note_request(scc_pkg::scc_req_type req);
      scc_pkg::scc_rsp_type rsp;
      int unsigned c;
      rsp = '0;
      case (req.kind)
         scc_pkg::KIND_ADD: begin
            if (req.first_index >= node_total || req.second_index >= node_total)
               rsp.status = scc_pkg::ST_RANGE;
            else if (edge_src.size() >= scc_pkg::MAX_EDGES)
               rsp.status = scc_pkg::ST_FULL;
            else begin
               edge_src = {edge_src, 32'(req.first_index)};
               edge_dst = {edge_dst, 32'(req.second_index)};
               run_valid = 0;
            end
         end
         scc_pkg::KIND_RUN: find_components();
         scc_pkg::KIND_QNODE: begin
            if (!run_valid) rsp.status = scc_pkg::ST_PHASE;
            else if (req.first_index >= node_total) rsp.status = scc_pkg::ST_RANGE;
            else begin
               c = comp_of[req.first_index];
               rsp.component_id = scc_pkg::NODE_W'(c);
               rsp.in_degree = scc_pkg::DEG_W'(cap_degree(comp_in[c]));
               rsp.out_degree = scc_pkg::DEG_W'(cap_degree(comp_out[c]));
            end
         end
         scc_pkg::KIND_QCOMP: begin
            if (!run_valid) rsp.status = scc_pkg::ST_PHASE;
            else if (req.first_index >= comp_found) rsp.status = scc_pkg::ST_RANGE;
            else begin
               rsp.component_id = req.first_index;
               rsp.in_degree = scc_pkg::DEG_W'(cap_degree(comp_in[req.first_index]));
               rsp.out_degree = scc_pkg::DEG_W'(cap_degree(comp_out[req.first_index]));
            end
         end
         scc_pkg::KIND_CLEAR: begin
            edge_src.delete();
            edge_dst.delete();
            run_valid = 0;
         end
         default: ;
      endcase
      rsp.component_total = run_valid ? scc_pkg::NCNT_W'(comp_found) : '0;
      pending_rsp = {pending_rsp, rsp};
   endfunction

   // compare one response beat with the oldest expectation
   function void check_response(scc_pkg::scc_rsp_type got);
      scc_pkg::scc_rsp_type want;
      rsp_checked++;
      if (pending_rsp.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("unexpected response beat: %p", got);
         return;
      end
      want = pending_rsp.pop_front();
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("response %0d mismatch: expected %p, got %p",
                     rsp_checked, want, got);
      end
   endfunction
endclass

@@ verif/tb_strongly_connected_components.sv @@
// ---------------------------------------------------------------------------
// tb_strongly_connected_components
// Loads small random graphs, runs the component search and queries nodes and
// components under varying node counts and handshake pressure, checking each
// response beat against a local predictor.
// ---------------------------------------------------------------------------
module tb_strongly_connected_components;
   timeunit 1ns;
   timeprecision 1ps;
   import scc_pkg::*;

   localparam int WATCHDOG_LIMIT = 400000;

   logic clock = 0;
   logic reset = 1;

   scc_req_if req_chan();
   scc_rsp_if rsp_chan();
   scc_csr_if csr_chan();

   strongly_connected_components u_top (
      .clock(clock), .reset(reset),
      .req_chan(req_chan), .rsp_chan(rsp_chan), .csr_chan(csr_chan)
   );

   scc_graph_checker graph_checker = new();

   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   bit          recv_hold = 0;
   int unsigned idle_cycles = 0;
   int unsigned beats_sent = 0;
   int unsigned runs_sent = 0;
   int unsigned cur_nodes = MAX_NODES;

   always #10 clock = ~clock;

   initial begin
      req_chan.valid = 0;
      req_chan.kind = '0;
      req_chan.first_index = '0;
      req_chan.second_index = '0;
      rsp_chan.ready = 0;
      csr_chan.valid = 0;
      csr_chan.data = '0;
   end

   // response side: random stalls, beat checking
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready)
            graph_checker.check_response('{rsp_chan.status, rsp_chan.component_id,
               rsp_chan.component_total, rsp_chan.in_degree, rsp_chan.out_degree});
         rsp_chan.ready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // watchdog on cycles without any beat
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
          || reset)
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired");
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // valid stays up across back-to-back beats; idle cycles and drain drop it
   task automatic send_beat(logic [KIND_W-1:0] kind, int unsigned a, int unsigned b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 0;
         @(posedge clock);
      end
      req_chan.valid <= 1;
      req_chan.kind <= kind;
      req_chan.first_index <= a[NODE_W-1:0];
      req_chan.second_index <= b[NODE_W-1:0];
      do @(posedge clock); while (!req_chan.ready);
      graph_checker.note_request('{kind, a[NODE_W-1:0], b[NODE_W-1:0]});
      beats_sent++;
      if (kind == KIND_RUN) runs_sent++;
   endtask

   task automatic drain();
      req_chan.valid <= 0;
      while (graph_checker.pending_rsp.size() > 0) @(posedge clock);
   endtask

   // written only when idle, after every response has come
   task automatic write_node_count(int unsigned value);
      drain();
      repeat (10) @(posedge clock);
      csr_chan.valid <= 1;
      csr_chan.data <= value[NCNT_W-1:0];
      do @(posedge clock); while (!csr_chan.ready);
      csr_chan.valid <= 0;
      graph_checker.write_node_count(value);
      cur_nodes = graph_checker.node_total;
   endtask

   function automatic int unsigned pick_node(int unsigned span);
      return (span == 0) ? 0 : $urandom_range(span - 1);
   endfunction

   // one graph: mostly in-range edges, some noise, a run and queries
   task automatic graph_round(int unsigned span, int unsigned edges, int unsigned queries);
      send_beat(KIND_CLEAR, $urandom, $urandom);
      for (int i = 0; i < edges; i++) begin
         if ($urandom_range(19) == 0)
            send_beat(KIND_ADD, $urandom_range(1023), $urandom_range(1023));
         else
            send_beat(KIND_ADD, pick_node(span), pick_node(span));
      end
      if ($urandom_range(9) == 0) send_beat(KIND_QNODE, pick_node(span), 0);
      send_beat(KIND_RUN, $urandom, $urandom);
      for (int i = 0; i < queries; i++) begin
         case ($urandom_range(9))
            0: send_beat(KIND_QNODE, $urandom_range(1023), $urandom);
            1: send_beat(KIND_QCOMP, $urandom_range(1023), $urandom);
            2: send_beat(KIND_W'($urandom_range(7, 5)), $urandom, $urandom);
            3, 4, 5: send_beat(KIND_QCOMP, pick_node(span), $urandom);
            default: send_beat(KIND_QNODE, pick_node(span), $urandom);
         endcase
      end
   endtask

   initial begin
      int unsigned span;
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: phase errors, range errors, cycles, unknown kinds
      write_node_count(4);
      send_beat(KIND_QNODE, 0, 0);
      send_beat(KIND_QCOMP, 0, 0);
      send_beat(KIND_ADD, 0, 1);
      send_beat(KIND_ADD, 1, 0);
      send_beat(KIND_ADD, 1, 2);
      send_beat(KIND_ADD, 2, 3);
      send_beat(KIND_ADD, 2, 3);
      send_beat(KIND_ADD, 4, 0);
      send_beat(KIND_ADD, 0, 1023);
      send_beat(KIND_RUN, 0, 0);
      send_beat(KIND_QNODE, 0, 0);
      send_beat(KIND_QNODE, 3, 0);
      send_beat(KIND_QNODE, 1023, 1023);
      send_beat(KIND_QCOMP, 2, 0);
      send_beat(KIND_QCOMP, 3, 0);
      send_beat(3'd7, 1023, 1023);
      send_beat(3'd5, 0, 0);
      send_beat(KIND_ADD, 3, 3);
      send_beat(KIND_QCOMP, 0, 0);
      write_node_count(2);
      send_beat(KIND_RUN, 0, 0);
      send_beat(KIND_QNODE, 1, 0);
      send_beat(KIND_CLEAR, 0, 0);
      send_beat(KIND_QNODE, 0, 0);

      // random phases with varying node counts and idling
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 53 : 35) : 0;
         recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 53 : 35) : 0;
         write_node_count(ph == 0 ? 0 : (ph == 3 ? 2047 : $urandom_range(2, 40)));
         for (int g = 0; g < 8; g++) begin
            span = (cur_nodes > 48) ? $urandom_range(2, 24) : cur_nodes;
            graph_round(span, $urandom_range(1, 3 * span), $urandom_range(4, 16));
         end
         // pause until everything has come back
         drain();
      end

      // held-off receiver while the sender keeps offering
      fork
         begin
            recv_hold = 1;
            repeat (300) @(posedge clock);
            recv_hold = 0;
         end
         begin
            for (int i = 0; i < 20; i++) send_beat(KIND_QCOMP, $urandom_range(3), 0);
         end
      join

      drain();
      repeat (20) @(posedge clock);
      $display("sent %0d request beats, %0d runs; %0d response beats checked",
               beats_sent, runs_sent, graph_checker.rsp_checked);
      $display("covered phase and range errors over node counts 1..1024");
      if (graph_checker.mismatch_count == 0 && graph_checker.pending_rsp.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule

@@ sim.f @@
rtl/scc_pkg.sv
rtl/scc_if.sv
rtl/scc_ram.sv
rtl/scc_core.sv
rtl/strongly_connected_components.sv
verif/tb_scc_scoreboard.sv
verif/tb_strongly_connected_components.sv
